// ===== hdl/pcs_pkg.sv =====
// ----------------------------------------------------------------------------
// PUCT child select package
// Shared widths, reset constants and the divider's request struct.
// ----------------------------------------------------------------------------
package pcs_pkg;
  localparam int MaxChildrenDef = 512;
  localparam logic [15:0] WeightReset = 16'd4096;
  localparam int DivW = 64;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] num;
    logic [DivW-1:0] den;
  } div_req_t;
endpackage

// ===== hdl/pcs_divider.sv =====
// ----------------------------------------------------------------------------
// PUCT child select divider
// Unsigned restoring divider: one quotient bit per cycle, DivW quotient bits a divide.
// ----------------------------------------------------------------------------
module pcs_divider
  import pcs_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  div_req_t        req,
  output logic            done,
  output logic [DivW-1:0] quo
);
  logic [DivW-1:0] rem, num, den;
  logic [6:0]      cnt;
  logic            busy;
  logic [DivW:0]   trial;

  assign trial = {rem, num[DivW-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem  <= '0;
        num  <= req.num;
        den  <= req.den;
        cnt  <= 7'(DivW);
      end else if (busy) begin
        num <= {num[DivW-2:0], ~trial[DivW]};
        rem <= trial[DivW] ? {rem[DivW-2:0], num[DivW-1]} : trial[DivW-1:0];
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quo = num;
endmodule

// ===== hdl/puct_child_select_core.sv =====
// ----------------------------------------------------------------------------
// PUCT child select core
// Scans a node's children one beat each and reports the best PUCT child.
// ----------------------------------------------------------------------------
// Usage: send one beat per child on the input channel, last_child high on the
// final child. The result channel carries one beat per run, after the last
// child: best_index, found and win_score. The explore_weight register is to
// be written through its own channel only while the block is idle; the
// block does not enforce this. The first beat of a run first runs a 32-step
// square root. Each present child then uses the shared 64-step divider
// twice (q, then u); an absent child skips the divider. The input is not
// ready while a child is worked on. The result sits in an output register;
// a stalled receiver holds the block only once the next run's last beat
// has been worked on. Reset clears the run state and loads explore_weight
// with 1.0.
// ----------------------------------------------------------------------------
module puct_child_select_core
  import pcs_pkg::*;
#(
  parameter int MAX_CHILDREN = MaxChildrenDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [19:0]        parent_visits,
  input  logic [15:0]        parent_pending,
  input  logic               child_present,
  input  logic [19:0]        child_visits,
  input  logic [15:0]        child_pending,
  input  logic signed [36:0] child_value_sum,
  input  logic [15:0]        child_prior,
  input  logic               last_child,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [8:0]         best_index,
  output logic               found,
  output logic signed [31:0] win_score
);
  localparam int CW = $clog2(MAX_CHILDREN + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_SQRT = 7'b0000010, S_QDIV = 7'b0000100,
    S_UDIV = 7'b0001000, S_CMP  = 7'b0010000, S_OUT  = 7'b0100000,
    S_MUL  = 7'b1000000
  } state_t;

  state_t state;
  logic [15:0] weight;
  logic [25:0] sqrt_parent;
  logic signed [31:0] best_value;
  logic [CW-1:0] best_slot, slot_counter;
  logic have_best, last_q, present_q, neg_q, dstart;
  logic [20:0] total;
  logic signed [37:0] numer;
  logic [15:0] prior_q;
  logic signed [64:0] qval;
  logic [63:0] prod;
  logic [63:0] sq_x, sq_r, sq_b;
  logic [4:0] sq_cnt;
  logic [DivW-1:0] dnum, dden, quo;
  logic ddone;
  logic signed [65:0] sum;
  logic signed [31:0] score;
  div_req_t req;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  assign req.start = dstart;
  assign req.num   = dnum;
  assign req.den   = dden;
  pcs_divider u_div (.clk(clk), .rst(rst), .req(req), .done(ddone), .quo(quo));

  assign sum = 66'(qval) + $signed({2'b0, quo});
  assign score = (sum > 66'sd2147483647) ? 32'sh7fffffff :
                 (sum < -66'sd2147483648) ? 32'sh80000000 : sum[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      weight <= WeightReset;
      sqrt_parent <= '0;
      best_value <= '0;
      best_slot <= '0;
      have_best <= 1'b0;
      slot_counter <= '0;
      out_valid <= 1'b0;
      dstart <= 1'b0;
    end else begin
      dstart <= 1'b0;
      if (cfg_valid && cfg_ready) weight <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          last_q    <= last_child;
          present_q <= child_present && (32'(slot_counter) < MAX_CHILDREN);
          total     <= 21'(child_visits) + 21'(child_pending);
          numer     <= 38'(child_value_sum) + $signed({6'b0, child_pending, 16'b0});
          prior_q   <= child_prior;
          if (slot_counter == '0) begin
            sq_x   <= 64'(21'(parent_visits) + 21'(parent_pending)) << 30;
            sq_r   <= '0;
            sq_b   <= 64'd1 << 62;
            sq_cnt <= 5'd31;
            state  <= S_SQRT;
          end else begin
            state <= S_MUL;
          end
        end
        S_SQRT: begin
          if (sq_x >= sq_r + sq_b) begin
            sq_x <= sq_x - (sq_r + sq_b);
            sq_r <= (sq_r >> 1) + sq_b;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_b <= sq_b >> 2;
          sq_cnt <= sq_cnt - 5'd1;
          if (sq_cnt == 5'd0) state <= S_MUL;
          if (sq_cnt == 5'd0) sqrt_parent <= 26'((sq_x >= sq_r + sq_b) ?
              (sq_r >> 1) + sq_b : sq_r >> 1);
        end
        S_MUL: begin
          prod <= 64'(32'(weight) * 32'(prior_q));
          if (!present_q) state <= S_CMP;
          else begin
            neg_q  <= numer[37];
            dnum   <= 64'(numer[37] ? -numer : numer);
            dden   <= (total == '0) ? 64'd1 : 64'(total);
            dstart <= 1'b1;
            state  <= S_QDIV;
          end
        end
        S_QDIV: if (ddone) begin
          qval   <= (total == '0) ? 65'sd0 :
                    neg_q ? $signed({1'b0, quo}) : -$signed({1'b0, quo});
          dnum   <= 64'(prod[31:0]) * 64'(sqrt_parent);
          dden   <= 64'(total + 21'd1) << 27;
          dstart <= 1'b1;
          state  <= S_UDIV;
        end
        S_UDIV: if (ddone) begin
          if (!have_best || score > best_value) begin
            best_value <= score;
            best_slot  <= slot_counter;
            have_best  <= 1'b1;
          end
          state <= S_CMP;
        end
        S_CMP: begin
          if (last_q) state <= S_OUT;
          else begin
            if (32'(slot_counter) < MAX_CHILDREN) slot_counter <= slot_counter + 1'b1;
            state <= S_IDLE;
          end
        end
        S_OUT: if (!out_valid) begin
          out_valid  <= 1'b1;
          best_index <= have_best ? 9'(best_slot) : 9'd0;
          found      <= have_best;
          win_score  <= have_best ? best_value : 32'sd0;
          sqrt_parent <= '0;
          best_value <= '0;
          best_slot <= '0;
          have_best <= 1'b0;
          slot_counter <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_hot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_found_score: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (win_score == 32'sd0 && best_index == 9'd0))
    else $error("empty result not zero");
endmodule
